[rtl/i8080bsd_pkg.sv]
// Package with the result type, mnemonic codes and opcode decode functions of the 8080 decoder.
package i8080bsd_pkg;

  // Result queue depth; one accepted byte can push up to two results.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Dense mnemonic numbers, in table order with JPE appended last.
  localparam logic [6:0] MN_ADC  = 7'd0,  MN_ADD  = 7'd1,  MN_ADI  = 7'd2,  MN_ANA  = 7'd3;
  localparam logic [6:0] MN_ANI  = 7'd4,  MN_CALL = 7'd5,  MN_CM   = 7'd6,  MN_CMA  = 7'd7;
  localparam logic [6:0] MN_CMC  = 7'd8,  MN_CMP  = 7'd9,  MN_CNC  = 7'd10, MN_CPE  = 7'd11;
  localparam logic [6:0] MN_CPI  = 7'd12, MN_CZ   = 7'd13, MN_DAA  = 7'd14, MN_DAD  = 7'd15;
  localparam logic [6:0] MN_DCR  = 7'd16, MN_DCX  = 7'd17, MN_DI   = 7'd18, MN_EI   = 7'd19;
  localparam logic [6:0] MN_IN   = 7'd20, MN_INR  = 7'd21, MN_INX  = 7'd22, MN_JC   = 7'd23;
  localparam logic [6:0] MN_JM   = 7'd24, MN_JMP  = 7'd25, MN_JNC  = 7'd26, MN_JNZ  = 7'd27;
  localparam logic [6:0] MN_JP   = 7'd28, MN_JPO  = 7'd29, MN_JZ   = 7'd30, MN_LDA  = 7'd31;
  localparam logic [6:0] MN_LDAX = 7'd32, MN_LXI  = 7'd33, MN_MOV  = 7'd34, MN_MVI  = 7'd35;
  localparam logic [6:0] MN_NOP  = 7'd36, MN_ORA  = 7'd37, MN_ORI  = 7'd38, MN_OUT  = 7'd39;
  localparam logic [6:0] MN_PCHL = 7'd40, MN_POP  = 7'd41, MN_PUSH = 7'd42, MN_RAR  = 7'd43;
  localparam logic [6:0] MN_RC   = 7'd44, MN_RET  = 7'd45, MN_RIM  = 7'd46, MN_RLC  = 7'd47;
  localparam logic [6:0] MN_RM   = 7'd48, MN_RNC  = 7'd49, MN_RNZ  = 7'd50, MN_RP   = 7'd51;
  localparam logic [6:0] MN_RPO  = 7'd52, MN_RRC  = 7'd53, MN_RST  = 7'd54, MN_RZ   = 7'd55;
  localparam logic [6:0] MN_SBB  = 7'd56, MN_SBI  = 7'd57, MN_SHLD = 7'd58, MN_SIM  = 7'd59;
  localparam logic [6:0] MN_STA  = 7'd60, MN_STAX = 7'd61, MN_SUB  = 7'd62, MN_SUI  = 7'd63;
  localparam logic [6:0] MN_XCHG = 7'd64, MN_XRA  = 7'd65, MN_XRI  = 7'd66, MN_XTHL = 7'd67;
  localparam logic [6:0] MN_JPE  = 7'd68;

  // Operand layout of an instruction.
  typedef enum logic [3:0] {
    K_NONE = 4'd0,
    K_ADDR = 4'd1,
    K_IMM  = 4'd2,
    K_R012 = 4'd3,
    K_R345 = 4'd4,
    K_RIMM = 4'd5,
    K_PAIR = 4'd6,
    K_PIMM = 4'd7,
    K_RR   = 4'd8
  } kind_t;

  localparam kind_t KIND_OF [0:68] = '{
    K_R012, K_R012, K_IMM,  K_R012, K_IMM,  K_ADDR, K_ADDR, K_NONE, K_NONE, K_R012,
    K_ADDR, K_ADDR, K_IMM,  K_ADDR, K_NONE, K_PAIR, K_R345, K_PAIR, K_NONE, K_NONE,
    K_IMM,  K_R345, K_PAIR, K_ADDR, K_ADDR, K_ADDR, K_ADDR, K_ADDR, K_ADDR, K_ADDR,
    K_ADDR, K_ADDR, K_PAIR, K_PIMM, K_RR,   K_RIMM, K_NONE, K_R012, K_IMM,  K_IMM,
    K_NONE, K_PAIR, K_PAIR, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE,
    K_NONE, K_NONE, K_NONE, K_NONE, K_R345, K_NONE, K_R012, K_IMM,  K_ADDR, K_NONE,
    K_ADDR, K_PAIR, K_R012, K_IMM,  K_NONE, K_R012, K_IMM,  K_NONE, K_ADDR
  };

  typedef struct packed {
    logic       known;
    logic [6:0] mn;
  } cls_t;

  typedef struct packed {
    logic [6:0]  mnemonic;
    logic        known;
    logic [15:0] start_address;
    logic [1:0]  byte_count;
    logic [7:0]  first_byte;
    logic [2:0]  dest_reg;
    logic [2:0]  src_reg;
    logic [1:0]  reg_pair;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic        last_of_run;
  } res_t;

  // Instruction length in bytes for an operand layout.
  function automatic logic [1:0] len_of(input kind_t k);
    logic [1:0] len;
    case (k)
      K_ADDR, K_PIMM: len = 2'd3;
      K_IMM, K_RIMM:  len = 2'd2;
      default:        len = 2'd1;
    endcase
    return len;
  endfunction

  // Opcode byte to mnemonic number, keeping the table's quirks.
  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c.known = 1'b1;
    c.mn    = MN_NOP;
    if (b[7:6] == 2'b01) begin
      c.mn = MN_MOV;
    end else begin
      case (b)
        8'h0f: c.mn = MN_RRC;  8'h1f: c.mn = MN_RAR;  8'h27: c.mn = MN_DAA;
        8'h2f: c.mn = MN_CMA;  8'h3f: c.mn = MN_CMC;  8'hc0: c.mn = MN_RNZ;
        8'hc2: c.mn = MN_JNZ;  8'hc3: c.mn = MN_JMP;  8'hc4: c.mn = MN_CZ;
        8'hc6: c.mn = MN_ADI;  8'hc8: c.mn = MN_RZ;   8'hc9: c.mn = MN_RET;
        8'hca: c.mn = MN_JZ;   8'hcc: c.mn = MN_CZ;   8'hcd: c.mn = MN_CALL;
        8'hd0: c.mn = MN_RNC;  8'hd2: c.mn = MN_JNC;  8'hd3: c.mn = MN_OUT;
        8'hd4: c.mn = MN_CNC;  8'hd6: c.mn = MN_SUI;  8'hd8: c.mn = MN_RC;
        8'hda: c.mn = MN_JC;   8'hdb: c.mn = MN_IN;   8'hde: c.mn = MN_SBI;
        8'he0: c.mn = MN_RPO;  8'he2: c.mn = MN_JPO;  8'he3: c.mn = MN_XTHL;
        8'he6: c.mn = MN_ANI;  8'he9: c.mn = MN_PCHL; 8'hea: c.mn = MN_JPE;
        8'heb: c.mn = MN_XCHG; 8'hec: c.mn = MN_CPE;  8'hee: c.mn = MN_XRI;
        8'hf0: c.mn = MN_RP;   8'hf2: c.mn = MN_JP;   8'hf3: c.mn = MN_DI;
        8'hf6: c.mn = MN_ORI;  8'hf8: c.mn = MN_RM;   8'hfa: c.mn = MN_JM;
        8'hfb: c.mn = MN_EI;   8'hfc: c.mn = MN_CM;   8'hfe: c.mn = MN_CPI;
        default: begin
          if (b[7]) begin
            // ALU group on a register, then the pattern families of the upper quarter.
            case (b[6:3])
              4'b0000: c.mn = MN_ADD;
              4'b0001: c.mn = MN_ADC;
              4'b0010: c.mn = MN_SUB;
              4'b0011: c.mn = MN_SBB;
              4'b0100: c.mn = MN_ANA;
              4'b0101: c.mn = MN_XRA;
              4'b0110: c.mn = MN_ORA;
              4'b0111: c.mn = MN_CMP;
              default: begin
                if (b[2:0] == 3'd1) c.mn = MN_POP;
                else if (b[3:0] == 4'd5) c.mn = MN_PUSH;
                else if (b[2:0] == 3'd7) c.mn = MN_RST;
                else c.known = 1'b0;
              end
            endcase
          end else begin
            case (b[3:0])
              4'h0: c.mn = (b == 8'h20) ? MN_RIM : ((b == 8'h30) ? MN_SIM : MN_NOP);
              4'h1: c.mn = MN_LXI;
              4'h2: c.mn = !b[5] ? MN_STAX : ((b == 8'h22) ? MN_SHLD : MN_STA);
              4'h3: c.mn = MN_INX;
              4'h7: c.mn = MN_RLC;
              4'h8: c.mn = MN_NOP;
              4'h9: c.mn = MN_DAD;
              4'ha: c.mn = b[5] ? MN_LDA : MN_LDAX;
              4'hb: c.mn = MN_DCX;
              default: begin
                case (b[2:0])
                  3'd4:    c.mn = MN_INR;
                  3'd5:    c.mn = MN_DCR;
                  default: c.mn = MN_MVI;
                endcase
              end
            endcase
          end
        end
      endcase
    end
    if (!c.known) c.mn = MN_ADC;
    return c;
  endfunction

  // A single byte that is passed on undecoded.
  function automatic res_t make_unknown(input logic [7:0] b, input logic [15:0] addr);
    res_t r;
    r               = '0;
    r.start_address = addr;
    r.byte_count    = 2'd1;
    r.first_byte    = b;
    return r;
  endfunction

  // A decoded instruction with its fields spread out by operand layout.
  function automatic res_t make_insn(input logic [6:0] mn, input logic [7:0] b0,
                                     input logic [7:0] b1, input logic [7:0] b2,
                                     input logic [15:0] addr);
    res_t  r;
    kind_t k;
    k               = KIND_OF[mn];
    r               = '0;
    r.mnemonic      = mn;
    r.known         = 1'b1;
    r.start_address = addr;
    r.byte_count    = len_of(k);
    r.first_byte    = b0;
    case (k)
      K_ADDR: begin
        r.operand_low  = b1;
        r.operand_high = b2;
      end
      K_IMM:  r.operand_low = b1;
      K_R012: r.dest_reg = b0[2:0];
      K_R345: r.dest_reg = b0[5:3];
      K_RIMM: begin
        r.dest_reg    = b0[5:3];
        r.operand_low = b1;
      end
      K_PAIR: r.reg_pair = b0[5:4];
      K_PIMM: begin
        r.reg_pair     = b0[5:4];
        r.operand_low  = b1;
        r.operand_high = b2;
      end
      K_RR: begin
        r.dest_reg = b0[5:3];
        r.src_reg  = b0[2:0];
        // MOV M,M is the halt slot and reads back as NOP.
        if (b0[5:3] == 3'd6 && b0[2:0] == 3'd6) r.mnemonic = MN_NOP;
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

[rtl/i8080bsd_in_if.sv]
// Channel interface that carries code bytes into the decoder.
interface i8080bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_data;

  modport source (output valid, output code_byte, output end_of_data, input ready);
  modport sink (input valid, input code_byte, input end_of_data, output ready);
endinterface

[rtl/i8080bsd_out_if.sv]
// Channel interface that carries decoded instructions out of the decoder.
interface i8080bsd_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  mnemonic;
  logic        known;
  logic [15:0] start_address;
  logic [1:0]  byte_count;
  logic [7:0]  first_byte;
  logic [2:0]  dest_reg;
  logic [2:0]  src_reg;
  logic [1:0]  reg_pair;
  logic [7:0]  operand_low;
  logic [7:0]  operand_high;
  logic        last_of_run;

  modport source (
    output valid, output mnemonic, output known, output start_address, output byte_count,
    output first_byte, output dest_reg, output src_reg, output reg_pair,
    output operand_low, output operand_high, output last_of_run, input ready
  );
  modport sink (
    input valid, input mnemonic, input known, input start_address, input byte_count,
    input first_byte, input dest_reg, input src_reg, input reg_pair,
    input operand_low, input operand_high, input last_of_run, output ready
  );
endinterface

[rtl/i8080_byte_stream_decoder.sv]
// Top level of the 8080 byte-stream instruction decoder.
//
//   Channel  Dir  Word                               Accepted when
//   code     in   code_byte, end_of_data             code.valid && code.ready
//   insn     out  one decoded instruction or byte    insn.valid && insn.ready
//
// One code byte is accepted per cycle. Its results, zero, one or two words, are written
// into a four-entry result queue in the same cycle and leave one per cycle while insn.ready
// is high. The input is ready while the queue has room for two words, which depends on queue
// state only, so output stalls reach the input in the next cycle through the queue count.
// Reset clears the pending-byte count, the instruction length and the address counter,
// and empties the queue.
module i8080_byte_stream_decoder (
  input logic            clk,
  input logic            rst,
  i8080bsd_in_if.sink    code,
  i8080bsd_out_if.source insn
);

  localparam int QAW = i8080bsd_pkg::QAW;

  // Decode state.
  logic [1:0]  pc;
  logic [1:0]  nl;
  logic [7:0]  p0;
  logic [7:0]  p1;
  logic [15:0] addr;

  // Result queue.
  i8080bsd_pkg::res_t q [i8080bsd_pkg::QDEPTH];
  logic [QAW-1:0]     head;
  logic [QAW-1:0]     tail;
  logic [QAW:0]       count;

  logic accept;
  logic pop;

  i8080bsd_pkg::cls_t cls_b;
  i8080bsd_pkg::cls_t cls_p;
  logic [1:0]         b_len;
  logic               fresh;
  logic               complete;
  logic               main_emit;
  i8080bsd_pkg::res_t main_res;
  logic [1:0]         pc_step;
  logic [1:0]         nl_step;
  logic [7:0]         p0_step;
  logic [7:0]         p1_step;
  logic [15:0]        addr_step;
  logic [1:0]         flush_cnt;
  logic [1:0]         pc_next;
  logic [1:0]         nl_next;
  logic [15:0]        addr_next;
  logic [1:0]         push;
  i8080bsd_pkg::res_t r0;
  i8080bsd_pkg::res_t r1;

  assign accept     = code.valid && code.ready;
  assign pop        = insn.valid && insn.ready;
  assign code.ready = (count <= (QAW+1)'(i8080bsd_pkg::QDEPTH - 2));

  // Decode the incoming byte against the pending bytes and build the results.
  always_comb begin
    cls_b     = i8080bsd_pkg::classify(code.code_byte);
    cls_p     = i8080bsd_pkg::classify(p0);
    b_len     = i8080bsd_pkg::len_of(i8080bsd_pkg::KIND_OF[cls_b.mn]);
    fresh     = (pc == 2'd0) || (pc == 2'd3) || (nl < 2'd2) || (pc >= nl);
    complete  = !fresh && ((pc + 2'd1) == nl);
    main_emit = 1'b0;
    main_res  = i8080bsd_pkg::make_unknown(code.code_byte, addr);
    pc_step   = pc;
    nl_step   = nl;
    p0_step   = p0;
    p1_step   = p1;
    addr_step = addr;
    if (fresh) begin
      pc_step = 2'd0;
      nl_step = 2'd0;
      if (!cls_b.known) begin
        main_emit = 1'b1;
        addr_step = addr + 16'd1;
      end else if (b_len == 2'd1) begin
        main_emit = 1'b1;
        main_res  = i8080bsd_pkg::make_insn(cls_b.mn, code.code_byte, 8'd0, 8'd0, addr);
        addr_step = addr + 16'(b_len);
      end else begin
        p0_step = code.code_byte;
        pc_step = 2'd1;
        nl_step = b_len;
      end
    end else if (complete) begin
      main_emit = 1'b1;
      main_res  = i8080bsd_pkg::make_insn(cls_p.mn, p0,
                                          (pc >= 2'd2) ? p1 : code.code_byte,
                                          (pc >= 2'd2) ? code.code_byte : 8'd0, addr);
      addr_step = addr + 16'(main_res.byte_count);
      pc_step   = 2'd0;
      nl_step   = 2'd0;
    end else begin
      if (pc[0]) p1_step = code.code_byte;
      else p0_step = code.code_byte;
      pc_step = pc + 2'd1;
    end

    // End of data flushes what is still pending as single unknown bytes.
    flush_cnt = (pc_step > 2'd2) ? 2'd2 : pc_step;
    pc_next   = pc_step;
    nl_next   = nl_step;
    addr_next = addr_step;
    if (code.end_of_data) begin
      pc_next   = 2'd0;
      nl_next   = 2'd0;
      addr_next = addr_step + 16'(flush_cnt);
    end

    r0   = main_res;
    r1   = i8080bsd_pkg::make_unknown(p1_step, addr_step + 16'd1);
    push = 2'd0;
    if (main_emit) begin
      push = 2'd1;
    end else if (code.end_of_data) begin
      r0   = i8080bsd_pkg::make_unknown(p0_step, addr_step);
      push = flush_cnt;
    end
    r0.last_of_run = (push == 2'd1);
    r1.last_of_run = (push == 2'd2);
  end

  // Decode state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= 2'd0;
      nl   <= 2'd0;
      addr <= 16'd0;
    end else if (accept) begin
      pc   <= pc_next;
      nl   <= nl_next;
      addr <= addr_next;
    end
  end

  // Pending bytes hold only what was written before being read.
  always_ff @(posedge clk) begin
    if (accept) begin
      p0 <= p0_step;
      p1 <= p1_step;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (accept && push != 2'd0) begin
      q[tail] <= r0;
      if (push == 2'd2) q[tail + QAW'(1)] <= r1;
    end
  end

  // Result queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (accept) tail <= tail + QAW'(push);
      if (pop) head <= head + QAW'(1);
      count <= count + (accept ? (QAW+1)'(push) : '0) - (QAW+1)'(pop);
    end
  end

  // Output word comes straight from the head of the queue.
  assign insn.valid         = (count != '0);
  assign insn.mnemonic      = q[head].mnemonic;
  assign insn.known         = q[head].known;
  assign insn.start_address = q[head].start_address;
  assign insn.byte_count    = q[head].byte_count;
  assign insn.first_byte    = q[head].first_byte;
  assign insn.dest_reg      = q[head].dest_reg;
  assign insn.src_reg       = q[head].src_reg;
  assign insn.reg_pair      = q[head].reg_pair;
  assign insn.operand_low   = q[head].operand_low;
  assign insn.operand_high  = q[head].operand_high;
  assign insn.last_of_run   = q[head].last_of_run;

  // The pending count and the instruction length always agree.
  a_pending_consistent: assert property (@(posedge clk) disable iff (rst)
    (pc == 2'd0 && nl == 2'd0) || (pc != 2'd0 && nl >= 2'd2 && pc < nl))
    else $error("pending byte count does not match instruction length");

  // End of data leaves nothing pending.
  a_eod_flushes: assert property (@(posedge clk) disable iff (rst)
    accept && code.end_of_data |=> pc == 2'd0)
    else $error("bytes still pending after end of data");

  // A word that is not the last of its run has its follower already queued.
  a_run_complete: assert property (@(posedge clk) disable iff (rst)
    insn.valid && !insn.last_of_run |-> count >= (QAW+1)'(2))
    else $error("run split across queue refills");

  // The queue never holds more words than it has entries.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(i8080bsd_pkg::QDEPTH))
    else $error("result queue overflow");

endmodule
